// ===== rtl/psp_pkg.sv =====
`timescale 1ns / 1ps

package psp_pkg;

  // Fixed point format of the axis, the sizes and the results.
  localparam int FRAC_BITS = 16;
  // Unit vector components are Q1.30.
  localparam int UNIT_BITS = 30;

  // Restoring square root: two bits of the radicand per step over 64 bits.
  localparam int ISQ_STEPS = 32;
  // Restoring division: one quotient bit per step, quotient is at most 2^30.
  localparam int DIV_STEPS = UNIT_BITS + 1;
  // Register stages of the normalizer: magnitude, leading one, shift, square,
  // sum, the root steps, the dividend setup and the divide steps.
  localparam int NORM_LAT = 5 + ISQ_STEPS + 1 + DIV_STEPS;

  localparam logic [30:0] MARGIN_RST =
    31'((((64'd1 << FRAC_BITS) * 64'd25) + 64'd500) / 64'd1000);
  localparam logic [31:0] YZ_THR_RST =
    32'(((64'd1 << (2 * FRAC_BITS)) + 64'd500000) / 64'd1000000);

  typedef enum logic [1:0] {
    FN_BOX      = 2'd0,
    FN_CAPSULE  = 2'd1,
    FN_SPHERE   = 2'd2,
    FN_CYLINDER = 2'd3
  } func_t;

  // Register index taken from paddr[2].
  localparam logic REG_MARGIN = 1'b0;
  localparam logic REG_YZ_THR = 1'b1;

  // Result of the normalizer: unit vector magnitudes in Q1.30.
  typedef struct packed {
    logic             zero;
    logic [2:0][30:0] mag;
  } norm_out_t;

endpackage

// ===== rtl/psp_norm.sv =====
`timescale 1ns / 1ps

// Pipelined unit vector: magnitudes are shifted as one so the largest lies in
// [2^29, 2^30), the length comes from a bit-serial square root and each
// component is divided by it with rounding.
module psp_norm (
  input  logic                clk,
  input  logic signed [31:0]  vec_x,
  input  logic signed [31:0]  vec_y,
  input  logic signed [31:0]  vec_z,
  output psp_pkg::norm_out_t  res
);

  logic [31:0] mag_in [3];
  logic [31:0] a_m_r [3];
  logic [31:0] a_mx_r;
  logic [31:0] b_m_r [3];
  logic [4:0]  b_pos_r;
  logic        b_zero_r;
  logic [29:0] c_m_r [3];
  logic        c_zero_r;
  logic [29:0] d_m_r [3];
  logic [59:0] d_sq_r [3];
  logic        d_zero_r;

  logic [63:0] sx_r [0:psp_pkg::ISQ_STEPS];
  logic [63:0] sr_r [0:psp_pkg::ISQ_STEPS];
  logic [29:0] sm_r [0:psp_pkg::ISQ_STEPS][3];
  logic        sz_r [0:psp_pkg::ISQ_STEPS];
  logic [63:0] isq_bit [0:psp_pkg::ISQ_STEPS-1];
  logic [63:0] isq_t [0:psp_pkg::ISQ_STEPS-1];
  logic        isq_ge [0:psp_pkg::ISQ_STEPS-1];

  logic [60:0] dr_r [0:psp_pkg::DIV_STEPS][3];
  logic [30:0] dq_r [0:psp_pkg::DIV_STEPS][3];
  logic [30:0] dl_r [0:psp_pkg::DIV_STEPS];
  logic        dz_r [0:psp_pkg::DIV_STEPS];
  logic [60:0] dv_sub [0:psp_pkg::DIV_STEPS-1][3];
  logic        dv_ge [0:psp_pkg::DIV_STEPS-1][3];
  logic [30:0] len;

  function automatic logic [4:0] lead_pos(logic [31:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

  always_comb begin
    mag_in[0] = vec_x[31] ? (~vec_x + 32'd1) : vec_x;
    mag_in[1] = vec_y[31] ? (~vec_y + 32'd1) : vec_y;
    mag_in[2] = vec_z[31] ? (~vec_z + 32'd1) : vec_z;
  end

  // Front: magnitude, largest magnitude, leading one, common shift, squares.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) a_m_r[i] <= mag_in[i];
    if (mag_in[0] >= mag_in[1] && mag_in[0] >= mag_in[2]) begin
      a_mx_r <= mag_in[0];
    end else if (mag_in[1] >= mag_in[2]) begin
      a_mx_r <= mag_in[1];
    end else begin
      a_mx_r <= mag_in[2];
    end

    for (int i = 0; i < 3; i++) b_m_r[i] <= a_m_r[i];
    b_pos_r  <= lead_pos(a_mx_r);
    b_zero_r <= (a_mx_r == '0);

    for (int i = 0; i < 3; i++) begin
      if (b_pos_r > 5'(psp_pkg::UNIT_BITS - 1)) begin
        c_m_r[i] <= 30'(b_m_r[i] >> (b_pos_r - 5'(psp_pkg::UNIT_BITS - 1)));
      end else begin
        c_m_r[i] <= 30'(b_m_r[i] << (5'(psp_pkg::UNIT_BITS - 1) - b_pos_r));
      end
    end
    c_zero_r <= b_zero_r;

    for (int i = 0; i < 3; i++) begin
      d_m_r[i]  <= c_m_r[i];
      d_sq_r[i] <= 60'(c_m_r[i]) * 60'(c_m_r[i]);
    end
    d_zero_r <= c_zero_r;
  end

  // Square root, one result bit per stage.
  always_comb begin
    for (int k = 0; k < psp_pkg::ISQ_STEPS; k++) begin
      isq_bit[k] = 64'd1 << (62 - 2 * k);
      isq_t[k]   = sr_r[k] + isq_bit[k];
      isq_ge[k]  = (sx_r[k] >= isq_t[k]);
    end
  end

  always_ff @(posedge clk) begin
    sx_r[0] <= 64'(d_sq_r[0]) + 64'(d_sq_r[1]) + 64'(d_sq_r[2]);
    sr_r[0] <= '0;
    for (int i = 0; i < 3; i++) sm_r[0][i] <= d_m_r[i];
    sz_r[0] <= d_zero_r;
    for (int k = 0; k < psp_pkg::ISQ_STEPS; k++) begin
      if (isq_ge[k]) begin
        sx_r[k+1] <= sx_r[k] - isq_t[k];
        sr_r[k+1] <= (sr_r[k] >> 1) + isq_bit[k];
      end else begin
        sx_r[k+1] <= sx_r[k];
        sr_r[k+1] <= sr_r[k] >> 1;
      end
      for (int i = 0; i < 3; i++) sm_r[k+1][i] <= sm_r[k][i];
      sz_r[k+1] <= sz_r[k];
    end
  end

  // Division of each scaled magnitude by the length, rounded to nearest.
  assign len = sr_r[psp_pkg::ISQ_STEPS][30:0];

  always_comb begin
    for (int j = 0; j < psp_pkg::DIV_STEPS; j++) begin
      for (int i = 0; i < 3; i++) begin
        dv_sub[j][i] = 61'(dl_r[j]) << (psp_pkg::DIV_STEPS - 1 - j);
        dv_ge[j][i]  = (dr_r[j][i] >= dv_sub[j][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dr_r[0][i] <= (61'(sm_r[psp_pkg::ISQ_STEPS][i]) << psp_pkg::UNIT_BITS) +
                    61'(len >> 1);
      dq_r[0][i] <= '0;
    end
    dl_r[0] <= len;
    dz_r[0] <= sz_r[psp_pkg::ISQ_STEPS];
    for (int j = 0; j < psp_pkg::DIV_STEPS; j++) begin
      for (int i = 0; i < 3; i++) begin
        dr_r[j+1][i] <= dv_ge[j][i] ? (dr_r[j][i] - dv_sub[j][i]) : dr_r[j][i];
        dq_r[j+1][i] <= dq_r[j][i] |
                        (31'(dv_ge[j][i]) << (psp_pkg::DIV_STEPS - 1 - j));
      end
      dl_r[j+1] <= dl_r[j];
      dz_r[j+1] <= dz_r[j];
    end
  end

  // A zero vector has no direction: all components read as zero.
  always_comb begin
    res.zero = dz_r[psp_pkg::DIV_STEPS];
    for (int i = 0; i < 3; i++) begin
      res.mag[i] = res.zero ? '0 : dq_r[psp_pkg::DIV_STEPS][i];
    end
  end

endmodule

// ===== rtl/primitive_shape_support_point.sv =====
`timescale 1ns / 1ps

// GJK support point of a box, x-aligned capsule, sphere or x-aligned cylinder,
// grown by the collision margin, in signed Q16.16 with saturated results.
// The block is fully pipelined: a new query is taken in every clock cycle,
// busy is never raised, and each result leaves on out_strobe once its start
// pulse has passed 1 input stage, 69 normalizer stages made of a 32-step
// square root and a 31-step divider, and 3 output stages. The receiver
// cannot stall the block, so results must be taken as they appear.
// Configuration writes through the APB port must only be made while no query
// is in flight.
module primitive_shape_support_point (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_axis_x,
  input  logic signed [31:0] in_axis_y,
  input  logic signed [31:0] in_axis_z,
  input  logic [30:0]        in_box_half_x,
  input  logic [30:0]        in_box_half_y,
  input  logic [30:0]        in_box_half_z,
  input  logic [30:0]        in_radius,
  input  logic [30:0]        in_half_length,
  output logic               out_strobe,
  output logic signed [31:0] out_support_x,
  output logic signed [31:0] out_support_y,
  output logic signed [31:0] out_support_z,
  output logic               out_axis_zero,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int L = psp_pkg::NORM_LAT;
  localparam logic signed [35:0] SAT_HI = 36'sd2147483647;
  localparam logic signed [35:0] SAT_LO = -36'sd2147483648;

  // Per-item data that travels beside the normalizers.
  typedef struct packed {
    psp_pkg::func_t func;
    logic           ax_pos;
    logic           ay_pos;
    logic           az_pos;
    logic           ax_neg;
    logic           ay_neg;
    logic           az_neg;
    logic [30:0]    hx;
    logic [30:0]    hy;
    logic [30:0]    hz;
    logic [30:0]    rad;
    logic [30:0]    hl;
    logic           cap;
  } side_t;

  // Configuration registers.
  logic [30:0] margin_r;
  logic [31:0] yz_thr_r;
  logic        cfg_wr;

  // Input stage.
  logic               in_vld_r;
  logic [1:0]         in_func_r;
  logic signed [31:0] in_ax_r, in_ay_r, in_az_r;
  logic [30:0]        in_hx_r, in_hy_r, in_hz_r, in_rad_r, in_hl_r;

  logic [31:0] mag_y, mag_z;
  logic [63:0] sq_y_r, sq_z_r;
  side_t       side_in;
  side_t       side_cap;
  side_t       side_r [0:L-1];
  logic        vld_r [0:L-1];

  psp_pkg::norm_out_t nu, nv;

  // Multiply stage.
  logic        m_vld_r;
  logic        m_zero_r;
  side_t       m_side_r;
  logic [62:0] m_pu_r [3];
  logic [62:0] m_pvy_r, m_pvz_r;
  logic [31:0] k1;

  // Combine stage.
  logic               r_vld_r;
  logic               r_zero_r;
  logic signed [35:0] r_res_r [3];
  logic signed [35:0] ru [3];
  logic signed [35:0] rvy, rvz, hl_s, hlm_s, hxm, hym, hzm;
  logic signed [35:0] res_nxt [3];

  function automatic logic [33:0] rnd30(logic [62:0] p);
    logic [63:0] t;
    t = 64'(p) + (64'd1 << (psp_pkg::UNIT_BITS - 1));
    return t[63:psp_pkg::UNIT_BITS];
  endfunction

  function automatic logic signed [35:0] with_sign(logic neg, logic [33:0] m);
    logic signed [35:0] v;
    v = signed'({2'b00, m});
    return neg ? -v : v;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [35:0] v);
    if (v > SAT_HI) return 32'sh7FFFFFFF;
    if (v < SAT_LO) return 32'sh80000000;
    return v[31:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port. Every transfer completes in its access cycle.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= psp_pkg::MARGIN_RST;
      yz_thr_r <= psp_pkg::YZ_THR_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        psp_pkg::REG_MARGIN: margin_r <= pwdata[30:0];
        psp_pkg::REG_YZ_THR: yz_thr_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      psp_pkg::REG_MARGIN: prdata = {1'b0, margin_r};
      psp_pkg::REG_YZ_THR: prdata = yz_thr_r;
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input stage. The pipeline never stalls, so a query is always accepted.
  // ---------------------------------------------------------------------------
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_func_r <= in_func;
    in_ax_r   <= in_axis_x;
    in_ay_r   <= in_axis_y;
    in_az_r   <= in_axis_z;
    in_hx_r   <= in_box_half_x;
    in_hy_r   <= in_box_half_y;
    in_hz_r   <= in_box_half_z;
    in_rad_r  <= in_radius;
    in_hl_r   <= in_half_length;
  end

  // ---------------------------------------------------------------------------
  // Two normalizers: the full axis, and its yz part for the cylinder rim.
  // ---------------------------------------------------------------------------
  psp_norm u_norm_axis (
    .clk   (clk),
    .vec_x (in_ax_r),
    .vec_y (in_ay_r),
    .vec_z (in_az_r),
    .res   (nu)
  );

  psp_norm u_norm_yz (
    .clk   (clk),
    .vec_x (32'sd0),
    .vec_y (in_ay_r),
    .vec_z (in_az_r),
    .res   (nv)
  );

  // ---------------------------------------------------------------------------
  // Side line. The cylinder cap test (yz length squared below the threshold)
  // is folded into the second entry once the squares are registered.
  // ---------------------------------------------------------------------------
  assign mag_y = in_ay_r[31] ? (~in_ay_r + 32'd1) : in_ay_r;
  assign mag_z = in_az_r[31] ? (~in_az_r + 32'd1) : in_az_r;

  always_comb begin
    side_in.func   = psp_pkg::func_t'(in_func_r);
    side_in.ax_pos = (in_ax_r > 32'sd0);
    side_in.ay_pos = (in_ay_r > 32'sd0);
    side_in.az_pos = (in_az_r > 32'sd0);
    side_in.ax_neg = in_ax_r[31];
    side_in.ay_neg = in_ay_r[31];
    side_in.az_neg = in_az_r[31];
    side_in.hx     = in_hx_r;
    side_in.hy     = in_hy_r;
    side_in.hz     = in_hz_r;
    side_in.rad    = in_rad_r;
    side_in.hl     = in_hl_r;
    side_in.cap    = 1'b0;
  end

  always_comb begin
    side_cap     = side_r[0];
    side_cap.cap = ((sq_y_r + sq_z_r) < 64'(yz_thr_r));
  end

  always_ff @(posedge clk) begin
    sq_y_r    <= 64'(mag_y) * 64'(mag_y);
    sq_z_r    <= 64'(mag_z) * 64'(mag_z);
    side_r[0] <= side_in;
    side_r[1] <= side_cap;
    for (int j = 2; j < L; j++) side_r[j] <= side_r[j-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < L; j++) vld_r[j] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld_r;
      for (int j = 1; j < L; j++) vld_r[j] <= vld_r[j-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Multiply stage: unit components times the radius plus margin (or the
  // margin alone for the cylinder), and the yz unit times the radius.
  // ---------------------------------------------------------------------------
  assign k1 = (side_r[L-1].func == psp_pkg::FN_CYLINDER) ? {1'b0, margin_r}
            : (32'(side_r[L-1].rad) + 32'(margin_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= vld_r[L-1];
    end
  end

  always_ff @(posedge clk) begin
    m_side_r <= side_r[L-1];
    m_zero_r <= nu.zero;
    for (int i = 0; i < 3; i++) m_pu_r[i] <= 63'(nu.mag[i]) * 63'(k1);
    m_pvy_r <= 63'(nv.mag[1]) * 63'(side_r[L-1].rad);
    m_pvz_r <= 63'(nv.mag[2]) * 63'(side_r[L-1].rad);
  end

  // ---------------------------------------------------------------------------
  // Combine stage: round the scaled terms, give them their signs and select
  // the point for the shape kind.
  // ---------------------------------------------------------------------------
  always_comb begin
    ru[0] = with_sign(m_side_r.ax_neg, rnd30(m_pu_r[0]));
    ru[1] = with_sign(m_side_r.ay_neg, rnd30(m_pu_r[1]));
    ru[2] = with_sign(m_side_r.az_neg, rnd30(m_pu_r[2]));
    rvy   = with_sign(m_side_r.ay_neg, rnd30(m_pvy_r));
    rvz   = with_sign(m_side_r.az_neg, rnd30(m_pvz_r));
    hl_s  = m_side_r.ax_pos ? 36'(m_side_r.hl) : -36'(m_side_r.hl);
    hlm_s = 36'(m_side_r.hl) + 36'(margin_r);
    hxm   = 36'(m_side_r.hx) + 36'(margin_r);
    hym   = 36'(m_side_r.hy) + 36'(margin_r);
    hzm   = 36'(m_side_r.hz) + 36'(margin_r);

    case (m_side_r.func)
      psp_pkg::FN_BOX: begin
        res_nxt[0] = m_side_r.ax_pos ? hxm : -hxm;
        res_nxt[1] = m_side_r.ay_pos ? hym : -hym;
        res_nxt[2] = m_side_r.az_pos ? hzm : -hzm;
      end
      psp_pkg::FN_CAPSULE: begin
        res_nxt[0] = ru[0] + hl_s;
        res_nxt[1] = ru[1];
        res_nxt[2] = ru[2];
      end
      psp_pkg::FN_SPHERE: begin
        res_nxt[0] = ru[0];
        res_nxt[1] = ru[1];
        res_nxt[2] = ru[2];
      end
      default: begin
        if (m_side_r.cap) begin
          // Axis almost along x: the support point is the cap center pushed out by the margin.
          res_nxt[0] = m_side_r.ax_pos ? hlm_s : -hlm_s;
          res_nxt[1] = '0;
          res_nxt[2] = '0;
        end else begin
          res_nxt[0] = ru[0] + hl_s;
          res_nxt[1] = rvy + ru[1];
          res_nxt[2] = rvz + ru[2];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_vld_r <= 1'b0;
    end else begin
      r_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    r_zero_r <= m_zero_r;
    for (int i = 0; i < 3; i++) r_res_r[i] <= res_nxt[i];
  end

  // ---------------------------------------------------------------------------
  // Output stage: saturate and present the transfer for one cycle.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= r_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_support_x <= sat32(r_res_r[0]);
    out_support_y <= sat32(r_res_r[1]);
    out_support_z <= sat32(r_res_r[2]);
    out_axis_zero <= r_zero_r;
  end

endmodule

// ===== bench/support_checker.sv =====
`timescale 1ns / 1ps

module support_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_axis_x,
  input  logic signed [31:0] in_axis_y,
  input  logic signed [31:0] in_axis_z,
  input  logic [30:0]        in_box_half_x,
  input  logic [30:0]        in_box_half_y,
  input  logic [30:0]        in_box_half_z,
  input  logic [30:0]        in_radius,
  input  logic [30:0]        in_half_length,
  input  logic               out_strobe,
  input  logic signed [31:0] out_support_x,
  input  logic signed [31:0] out_support_y,
  input  logic signed [31:0] out_support_z,
  input  logic               out_axis_zero,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);

  typedef struct {
    logic signed [31:0] sx, sy, sz;
    logic               az;
  } point_t;

  point_t points_due[$];
  logic [30:0] cur_margin;
  logic [31:0] cur_thr;

  function automatic logic [63:0] mag64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Unit vector in Q1.30; all zero when the vector is zero.
  function automatic logic normalize(input longint a[3], output longint u[3]);
    logic [63:0] m[3], mx, len2, len, q;
    int rsh, lsh;
    mx = 0; len2 = 0; rsh = 0; lsh = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag64(a[i]);
      if (m[i] > mx) mx = m[i];
      u[i] = 0;
    end
    if (mx == 0) return 1'b0;
    while (mx >= (64'd1 << psp_pkg::UNIT_BITS)) begin mx >>= 1; rsh++; end
    while (mx < (64'd1 << (psp_pkg::UNIT_BITS - 1))) begin mx <<= 1; lsh++; end
    for (int i = 0; i < 3; i++) begin
      m[i] = (m[i] >> rsh) << lsh;
      len2 += m[i] * m[i];
    end
    len = int_sqrt(len2);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << psp_pkg::UNIT_BITS) + (len >> 1)) / len;
      u[i] = a[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic longint scale_unit(longint u, logic [63:0] k);
    logic [63:0] mu, kh, kl, r;
    mu = mag64(u);
    kh = k >> psp_pkg::UNIT_BITS;
    kl = k & ((64'd1 << psp_pkg::UNIT_BITS) - 1);
    r = mu * kh + ((mu * kl + (64'd1 << (psp_pkg::UNIT_BITS - 1))) >> psp_pkg::UNIT_BITS);
    return u < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  function automatic logic [63:0] sq_clamp(logic [63:0] m);
    return m >= (64'd1 << 32) ? '1 : m * m;
  endfunction

  function automatic point_t support_of(psp_pkg::func_t fn, longint a[3],
                                        longint half[3], longint rad, longint hl);
    longint u[3], v[3], yz[3], p[3], h;
    logic [63:0] sy, sz, s;
    logic nz;
    point_t r;
    p = '{0, 0, 0};
    nz = normalize(a, u);
    case (fn)
      psp_pkg::FN_BOX: begin
        for (int i = 0; i < 3; i++) begin
          h = half[i] + cur_margin;
          p[i] = a[i] > 0 ? h : -h;
        end
      end
      psp_pkg::FN_CAPSULE, psp_pkg::FN_SPHERE: begin
        for (int i = 0; i < 3; i++) p[i] = scale_unit(u[i], rad + cur_margin);
        if (fn == psp_pkg::FN_CAPSULE) p[0] += a[0] > 0 ? hl : -hl;
      end
      default: begin
        sy = sq_clamp(mag64(a[1]));
        sz = sq_clamp(mag64(a[2]));
        s = (sy > ~sz) ? '1 : sy + sz;
        if (s < cur_thr) begin
          h = hl + cur_margin;
          p[0] = a[0] > 0 ? h : -h;
        end else begin
          yz = '{0, a[1], a[2]};
          void'(normalize(yz, v));
          for (int i = 0; i < 3; i++)
            p[i] = scale_unit(v[i], rad) + scale_unit(u[i], cur_margin);
          p[0] += a[0] > 0 ? hl : -hl;
        end
      end
    endcase
    r.sx = clamp32(p[0]); r.sy = clamp32(p[1]); r.sz = clamp32(p[2]);
    r.az = !nz;
    return r;
  endfunction

  assign pending = points_due.size();

  always @(posedge clk) begin
    longint a[3], half[3];
    point_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      cur_margin <= psp_pkg::MARGIN_RST;
      cur_thr    <= psp_pkg::YZ_THR_RST;
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == psp_pkg::REG_MARGIN) cur_margin <= pwdata[30:0];
        else cur_thr <= pwdata;
      end
      if (out_strobe) begin
        if (points_due.size() == 0) begin
          $error("result transfer with no query outstanding");
          errs++;
        end else begin
          want = points_due.pop_front();
          if (out_support_x !== want.sx) begin
            $error("support_x expected %0d got %0d", want.sx, out_support_x);
            errs++;
          end
          if (out_support_y !== want.sy) begin
            $error("support_y expected %0d got %0d", want.sy, out_support_y);
            errs++;
          end
          if (out_support_z !== want.sz) begin
            $error("support_z expected %0d got %0d", want.sz, out_support_z);
            errs++;
          end
          if (out_axis_zero !== want.az) begin
            $error("axis_zero expected %0d got %0d", want.az, out_axis_zero);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      if (start && !busy) begin
        a = '{in_axis_x, in_axis_y, in_axis_z};
        half = '{in_box_half_x, in_box_half_y, in_box_half_z};
        points_due.push_back(support_of(psp_pkg::func_t'(in_func), a, half,
                                        in_radius, in_half_length));
      end
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the support point block. The checker beside the
// block predicts every result and counts mismatches; this module drives query
// transfers and register writes, runs a watchdog and decides pass or fail.
module testbench;

  localparam int LATENCY = 73;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_func = '0;
  logic signed [31:0] in_axis_x = '0, in_axis_y = '0, in_axis_z = '0;
  logic [30:0] in_box_half_x = '0, in_box_half_y = '0, in_box_half_z = '0;
  logic [30:0] in_radius = '0, in_half_length = '0;
  logic out_strobe, out_axis_zero;
  logic signed [31:0] out_support_x, out_support_y, out_support_z;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending;
  int cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  primitive_shape_support_point u_top (.*);

  support_checker u_chk (.*);

  // A generous watchdog: the whole run is far below this when correct.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("primitive_shape_support_point verification failed");
      $finish;
    end
  end

  // Write one register through the two-phase APB handshake.
  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // Registers change only once every result in flight has been taken.
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Axis values mix the full range, tiny magnitudes, zero and extremes.
  function automatic logic [31:0] pick_axis();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'h80000000;
      2: return 32'h7fffffff;
      3: return $urandom_range(0, 7) - 3;
      4: return $urandom_range(0, 4095) - 2048;
      5: return $urandom_range(0, 32'h3ffff) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] pick_size();
    case ($urandom_range(0, 7))
      0: return 31'h0;
      1: return 31'h7fffffff;
      2: return $urandom_range(0, 32'h7ffff);
      default: return 31'($urandom);
    endcase
  endfunction

  // Present one query; it transfers at the rising edge where busy is low.
  task automatic send(logic [1:0] fn, logic [31:0] ax, ay, az,
                      logic [30:0] hx, hy, hz, rad, hl);
    in_func = fn; in_axis_x = ax; in_axis_y = ay; in_axis_z = az;
    in_box_half_x = hx; in_box_half_y = hy; in_box_half_z = hz;
    in_radius = rad; in_half_length = hl;
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic random_gap();
    int n;
    n = $urandom_range(0, 19) == 0 ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) n = 0;
    if (n > 0) begin
      start = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic random_phase(int count, bit burst);
    for (int i = 0; i < count; i++) begin
      send($urandom_range(0, 3), pick_axis(), pick_axis(), pick_axis(),
           pick_size(), pick_size(), pick_size(), pick_size(), pick_size());
      if (!burst) random_gap();
    end
    start = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: every shape with the extreme and degenerate axes.
    for (int f = psp_pkg::FN_BOX; f <= psp_pkg::FN_CYLINDER; f++) begin
      send(f, 0, 0, 0, 5, 6, 7, 8, 9);
      send(f, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
           '1, '1, '1, '1, '1);
      send(f, 32'h80000000, 32'h80000000, 32'h80000000,
           '1, '1, '1, '1, '1);
      send(f, 32'h10000, 0, 0, 32'h10000, 32'h20000, 32'h30000,
           32'h10000, 32'h20000);
      send(f, -32'sd1, 1, 1, 1, 1, 1, 1, 1);
    end
    // Cylinder with yz just below and just above the default threshold.
    send(psp_pkg::FN_CYLINDER, 32'h10000, 65, 0, 0, 0, 0, 32'h10000, 32'h10000);
    send(psp_pkg::FN_CYLINDER, 32'h10000, 66, 0, 0, 0, 0, 32'h10000, 32'h10000);
    start = 1'b0;
    random_phase(450, 1'b0);
    drain();

    write_reg(psp_pkg::REG_MARGIN, 32'h0);
    write_reg(psp_pkg::REG_YZ_THR, 32'h0);
    // Zero threshold makes a zero yz reach the rim branch.
    send(psp_pkg::FN_CYLINDER, 32'h10000, 0, 0, 0, 0, 0, 32'h10000, 32'h10000);
    start = 1'b0;
    random_phase(450, 1'b1);
    drain();

    write_reg(psp_pkg::REG_MARGIN, 32'hffffffff);
    write_reg(psp_pkg::REG_YZ_THR, 32'hffffffff);
    random_phase(450, 1'b0);
    drain();

    write_reg(psp_pkg::REG_MARGIN, $urandom);
    write_reg(psp_pkg::REG_YZ_THR, $urandom_range(0, 32'h3fffffff));
    random_phase(480, 1'b0);
    drain();

    if (fail_count == 0) begin
      $display("primitive_shape_support_point verification clean");
    end else begin
      $display("primitive_shape_support_point verification failed");
    end
    $finish;
  end

endmodule
